/* design/ffbe_pkg.sv */
package ffbe_pkg;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] left_result;
        logic signed [23:0] right_result;
    } out_item_t;

    localparam int unsigned REG_F1    = 0;
    localparam int unsigned REG_F2    = 1;
    localparam int unsigned REG_F3    = 2;
    localparam int unsigned REG_ENV   = 3;
    localparam int unsigned REG_DRIVE = 4;
    localparam int unsigned REG_MIX   = 5;

    localparam int unsigned MIX_ONE = 65536;

    // one state word per channel: x1, x2 (24 each), env (24), 3 x (y1, y2) (32 each)
    localparam int unsigned STATE_W = 24 * 3 + 32 * 6;

endpackage

/* design/ffbe_ram.sv */
module ffbe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/formant_filter_bank_envelope.sv */
// Stereo formant filter bank with peak envelope follower.
// Input channel: in_valid/in_stall/in_data carry one stereo Q1.23 pair per
//   transaction. Output channel: out_valid/out_stall/out_data return one
//   saturated pair per input transaction, in order.
// Configuration: APB-style, 64-bit data, register i at byte 8*i; pready is
//   always high. Write registers only while no transaction is in flight.
// Timing: the left channel is processed first, then the right; the output
//   state then raises out_valid. A new pair is not accepted until the
//   previous one is through. A single shared 38x26
//   multiplier, with a register after it, runs every product of both channels
//   in sequence; that multiplier sets the rate. Per-channel state (input
//   history, envelope, band output history) lives in one synchronous RAM of
//   two words, read at the start of a channel and written back at its end.
// Reset: the state RAM has no reset, so a clearing pass writes zero to both
//   words, one after the other, after reset; no input is taken meanwhile. All
//   configuration registers reset to zero.
// Stall: the result sits in an output register; a new pair is accepted
//   only after the previous result has been taken.
module formant_filter_bank_envelope (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ffbe_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ffbe_pkg::out_item_t   out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    localparam int unsigned SW = ffbe_pkg::STATE_W;

    // ---------------- configuration registers ----------------
    logic [53:0] f_reg [3];
    logic [35:0] env_c_reg;
    logic [18:0] drive_reg;
    logic [16:0] mix_reg;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg[0]  <= '0;
            f_reg[1]  <= '0;
            f_reg[2]  <= '0;
            env_c_reg <= '0;
            drive_reg <= '0;
            mix_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                3'(ffbe_pkg::REG_F1):    f_reg[0]  <= pwdata[53:0];
                3'(ffbe_pkg::REG_F2):    f_reg[1]  <= pwdata[53:0];
                3'(ffbe_pkg::REG_F3):    f_reg[2]  <= pwdata[53:0];
                3'(ffbe_pkg::REG_ENV):   env_c_reg <= pwdata[35:0];
                3'(ffbe_pkg::REG_DRIVE): drive_reg <= pwdata[18:0];
                3'(ffbe_pkg::REG_MIX):   mix_reg   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            3'(ffbe_pkg::REG_F1):    prdata = {10'd0, f_reg[0]};
            3'(ffbe_pkg::REG_F2):    prdata = {10'd0, f_reg[1]};
            3'(ffbe_pkg::REG_F3):    prdata = {10'd0, f_reg[2]};
            3'(ffbe_pkg::REG_ENV):   prdata = {28'd0, env_c_reg};
            3'(ffbe_pkg::REG_DRIVE): prdata = {45'd0, drive_reg};
            3'(ffbe_pkg::REG_MIX):   prdata = {47'd0, mix_reg};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_ENV   = 9'b000001000, // envelope product
        S_BAND  = 9'b000010000, // three products per band
        S_MOD   = 9'b000100000, // env*drive, then wet*envmod
        S_MIX   = 9'b001000000, // two mix products
        S_WB    = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t      st_reg, st_next;
    logic [2:0]  step_reg;      // sub-step within a phase
    logic [1:0]  band_reg;
    logic        ch_reg;
    logic        clr_reg;

    ffbe_pkg::in_item_t  in_reg;
    ffbe_pkg::out_item_t res_reg;
    logic                out_valid_reg;

    // state word fields
    logic [SW-1:0]       rd_data;
    logic signed [23:0]  x1_reg, x2_reg;
    logic [23:0]         env_reg;
    logic signed [31:0]  y1_reg [3];
    logic signed [31:0]  y2_reg [3];

    // shared multiplier: wide operand on ma, narrow one on mb
    logic signed [37:0]  ma;
    logic signed [25:0]  mb;
    logic signed [63:0]  mul_out;
    logic signed [65:0]  prod_reg;
    logic signed [65:0]  acc_reg;
    logic signed [34:0]  wet_reg;
    logic signed [23:0]  x_cur;

    assign x_cur   = ch_reg ? in_reg.right_sample : in_reg.left_sample;
    assign mul_out = ma * mb;

    logic signed [24:0] target;
    logic signed [24:0] env_s;
    logic               att_sel;
    assign target  = x_cur[23] ? -25'(x_cur) : 25'(x_cur);
    assign env_s   = {1'b0, env_reg};
    assign att_sel = target > env_s;

    logic signed [17:0] g_c, a1_c, a2_c;
    assign g_c  = f_reg[band_reg][17:0];
    assign a1_c = f_reg[band_reg][35:18];
    assign a2_c = f_reg[band_reg][53:36];

    logic [16:0] m_c;
    assign m_c = (mix_reg > 17'(ffbe_pkg::MIX_ONE)) ? 17'(ffbe_pkg::MIX_ONE) : mix_reg;

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (st_reg)
            S_ENV:
            begin
                ma = 38'(target - env_s);
                mb = 26'(att_sel ? $signed({1'b0, env_c_reg[17:0]})
                                 : $signed({1'b0, env_c_reg[35:18]}));
            end
            S_BAND:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        ma = 38'(25'(x_cur) - 25'(x2_reg));
                        mb = 26'(g_c);
                    end
                    3'd1:
                    begin
                        ma = 38'(y1_reg[band_reg]);
                        mb = 26'(a1_c);
                    end
                    default:
                    begin
                        ma = 38'(y2_reg[band_reg]);
                        mb = 26'(a2_c);
                    end
                endcase
            end
            S_MOD:
            begin
                if (step_reg == 3'd0)
                begin
                    ma = 38'($signed({1'b0, env_reg}));
                    mb = 26'($signed({1'b0, drive_reg}));
                end
                else
                begin
                    // wet needs 34 bits signed; envmod (below 2^21) held in acc_reg
                    ma = 38'(wet_reg);
                    mb = acc_reg[25:0];
                end
            end
            S_MIX:
            begin
                if (step_reg == 3'd0)
                begin
                    ma = 38'(x_cur);
                    mb = 26'($signed({1'b0, 17'(17'(ffbe_pkg::MIX_ONE) - m_c)}));
                end
                else
                begin
                    // acc_reg holds scaled (38 bits signed) during step 1
                    ma = acc_reg[37:0];
                    mb = 26'($signed({1'b0, m_c}));
                end
            end
            default: ;
        endcase
    end

    // rounding and saturation helpers
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic signed [65:0] band_acc;
    logic signed [65:0] band_rnd;
    assign band_acc = acc_reg - prod_reg;
    assign band_rnd = (band_acc + 66'sd32768) >>> 16;

    logic        we;
    logic        waddr;
    logic [SW-1:0] wdata;
    logic        raddr;

    ffbe_ram #(.WIDTH(SW), .DEPTH(2)) u_state (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // during write-back of the left channel the right word is already addressed
    assign raddr = (st_reg == S_WB) ? 1'b1 : ch_reg;
    assign we    = (st_reg == S_CLR) || (st_reg == S_WB);
    assign waddr = (st_reg == S_CLR) ? clr_reg : ch_reg;
    assign wdata = (st_reg == S_CLR) ? '0 :
                   {x_cur, x1_reg, env_reg, y1_reg[0], y2_reg[0], y1_reg[1], y2_reg[1],
                    y1_reg[2], y2_reg[2]};

    logic signed [65:0] mixed;
    logic signed [23:0] mix_sat;
    assign mixed   = (acc_reg + prod_reg + 66'sd32768) >>> 16;
    assign mix_sat = (mixed > 66'sd8388607) ? 24'sh7fffff :
                     (mixed < -66'sd8388608) ? 24'sh800000 : mixed[23:0];

    assign in_stall  = (st_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLR:  if (clr_reg) st_next = S_IDLE;
            S_IDLE: if (in_valid && !in_stall) st_next = S_RD;
            S_RD:   st_next = S_ENV;
            S_ENV:  if (step_reg == 3'd2) st_next = S_BAND;
            S_BAND: if (step_reg == 3'd3 && band_reg == 2'd2) st_next = S_MOD;
            S_MOD:  if (step_reg == 3'd3) st_next = S_MIX;
            S_MIX:  if (step_reg == 3'd2) st_next = S_WB;
            S_WB:   st_next = ch_reg ? S_OUT : S_RD;
            S_OUT:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLR;
            step_reg      <= '0;
            band_reg      <= '0;
            ch_reg        <= 1'b0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_CLR)
                clr_reg <= 1'b1;
            if (st_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (st_next != st_reg || (st_reg == S_BAND && step_reg == 3'd3))
                step_reg <= '0;
            else
                step_reg <= step_reg + 3'd1;
            if (st_reg == S_IDLE || st_reg == S_WB)
                band_reg <= '0;
            else if (st_reg == S_BAND && step_reg == 3'd3)
                band_reg <= band_reg + 2'd1;
            if (st_reg == S_IDLE)
                ch_reg <= 1'b0;
            else if (st_reg == S_WB)
                ch_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(mul_out);
        if (st_reg == S_IDLE)
            in_reg <= in_data;
        if (st_reg == S_RD)
        begin
            // rdata holds the word addressed in the cycle before
            x1_reg  <= rd_data[SW-1 -: 24];
            x2_reg  <= rd_data[SW-25 -: 24];
            env_reg <= rd_data[SW-49 -: 24];
            y1_reg[0] <= rd_data[191:160];
            y2_reg[0] <= rd_data[159:128];
            y1_reg[1] <= rd_data[127:96];
            y2_reg[1] <= rd_data[95:64];
            y1_reg[2] <= rd_data[63:32];
            y2_reg[2] <= rd_data[31:0];
            wet_reg <= '0;
        end
        case (st_reg)
            S_ENV:
                if (step_reg == 3'd1)
                    env_reg <= 24'(25'(env_s + 25'(prod_reg >>> 18)));
            S_BAND:
            begin
                case (step_reg)
                    3'd1: acc_reg <= prod_reg;
                    3'd2: acc_reg <= band_acc;
                    3'd3:
                    begin
                        y2_reg[band_reg] <= y1_reg[band_reg];
                        y1_reg[band_reg] <= sat32(band_rnd);
                        wet_reg <= wet_reg + 35'(sat32(band_rnd));
                    end
                    default: ;
                endcase
            end
            S_MOD:
            begin
                if (step_reg == 3'd1)
                    acc_reg <= 66'sd65536 + (prod_reg >>> 23);
                else if (step_reg == 3'd3)
                    acc_reg <= (prod_reg + 66'sd32768) >>> 16;
            end
            S_MIX:
            begin
                if (step_reg == 3'd1)
                    acc_reg <= prod_reg;
                else if (step_reg == 3'd2)
                begin
                    // acc_reg = x*(1-m), prod_reg = scaled*m
                    if (ch_reg)
                        res_reg.right_result <= mix_sat;
                    else
                        res_reg.left_result <= mix_sat;
                end
            end
            default: ;
        endcase
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) (st_reg != S_IDLE) |-> in_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_after_wb;
        @(posedge clk) disable iff (!rst_n) $rose(out_valid_reg) |-> $past(st_reg == S_OUT);
    endproperty
    a_out_after_wb: assert property (p_out_after_wb) else $error("result without sequence");

    property p_we_states;
        @(posedge clk) disable iff (!rst_n) we |-> (st_reg == S_CLR || st_reg == S_WB);
    endproperty
    a_we_states: assert property (p_we_states) else $error("stray state write");
endmodule

/* tb/formant_filter_bank_envelope_test.sv */
module formant_filter_bank_envelope_test;

    // Cycles without any accepted transaction before the run is declared hung.
    // The longest receiver hold is HOLD_CYCLES.
    localparam int HANG_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 40;      // settle time after the last result
    localparam int HOLD_CYCLES = 300;     // long receiver back-pressure stretch
    localparam int IDLE_PCT    = 27;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    ffbe_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    ffbe_pkg::out_item_t out_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    formant_filter_bank_envelope u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state. It is a private copy of the configuration and of the per-channel history.
    // ------------------------------------------------------------------
    logic [53:0] band_coeffs [3];
    logic [35:0] env_coeffs;
    logic [18:0] drive_q16;
    logic [16:0] wet_level;

    longint dry_hist  [2][2];      // x[n-1], x[n-2]
    longint band_hist [2][3][2];   // y[n-1], y[n-2] per band
    longint env_track [2];

    ffbe_pkg::in_item_t  pending_pairs [$];
    ffbe_pkg::out_item_t expected_pairs [$];

    int  errors = 0;
    bit  no_idle = 1'b0;           // phase with no idling on either side
    int  hold_req = 0;             // bumped to request a long receiver hold
    int  hold_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // One channel of the filter bank; advances the predictor state.
    function automatic longint shape_channel(int ch, longint x);
        longint target;
        longint coef;
        longint att;
        longint rel;
        longint g;
        longint a1;
        longint a2;
        longint acc;
        longint y;
        longint wet;
        longint drv;
        longint envmod;
        longint scaled;
        longint m;
        longint x2;
        longint one;
        target = (x < 0) ? -x : x;
        att = env_coeffs[17:0];
        rel = env_coeffs[35:18];
        coef = (target > env_track[ch]) ? att : rel;
        // envelope update floors (arithmetic shift)
        env_track[ch] = env_track[ch] + ((coef * (target - env_track[ch])) >>> 18);

        x2 = dry_hist[ch][1];
        wet = 0;
        for (int f = 0; f < 3; f++)
        begin
            g  = $signed(band_coeffs[f][17:0]);
            a1 = $signed(band_coeffs[f][35:18]);
            a2 = $signed(band_coeffs[f][53:36]);
            acc = g * (x - x2) - a1 * band_hist[ch][f][0] - a2 * band_hist[ch][f][1];
            y = clamp_signed(round_half_up(acc, 16), 32);
            band_hist[ch][f][1] = band_hist[ch][f][0];
            band_hist[ch][f][0] = y;
            wet += y;
        end
        dry_hist[ch][1] = dry_hist[ch][0];
        dry_hist[ch][0] = x;

        drv = drive_q16;
        envmod = (64'sd1 <<< 16) + ((env_track[ch] * drv) >>> 23);
        scaled = round_half_up(wet * envmod, 16);

        one = longint'(ffbe_pkg::MIX_ONE);
        m = (wet_level > ffbe_pkg::MIX_ONE) ? one : longint'(wet_level);
        return clamp_signed(round_half_up(x * (one - m) + scaled * m, 16), 24);
    endfunction

    function automatic void predict_pair(ffbe_pkg::in_item_t it);
        ffbe_pkg::out_item_t e;
        longint l;
        longint r;
        l = it.left_sample;
        r = it.right_sample;
        e.left_result  = 24'(shape_channel(0, l));
        e.right_result = 24'(shape_channel(1, r));
        expected_pairs.push_back(e);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued pairs, holds a stalled transaction steady.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            predict_pair(in_data);
        if (!in_valid || !in_stall)
        begin
            if (rst_n && pending_pairs.size() > 0
                && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                in_data  <= pending_pairs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result and drives receiver back-pressure.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_pairs.size() == 0)
            begin
                $error("unexpected result transaction: %0d %0d",
                       out_data.left_result, out_data.right_result);
                errors++;
            end
            else
            begin
                ffbe_pkg::out_item_t e;
                e = expected_pairs.pop_front();
                if (out_data.left_result !== e.left_result)
                begin
                    $error("left_result expected %0d actual %0d",
                           e.left_result, out_data.left_result);
                    errors++;
                end
                if (out_data.right_result !== e.right_result)
                begin
                    $error("right_result expected %0d actual %0d",
                           e.right_result, out_data.right_result);
                    errors++;
                end
            end
        end

        // A long hold lets the block fill up and stall its input.
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= rst_n && !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: no transaction on either channel for too long means hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Register writes and stimulus helpers
    // ------------------------------------------------------------------
    task automatic reg_write(int idx, logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ffbe_pkg::REG_F1:    band_coeffs[0] = v[53:0];
            ffbe_pkg::REG_F2:    band_coeffs[1] = v[53:0];
            ffbe_pkg::REG_F3:    band_coeffs[2] = v[53:0];
            ffbe_pkg::REG_ENV:   env_coeffs = v[35:0];
            ffbe_pkg::REG_DRIVE: drive_q16 = v[18:0];
            ffbe_pkg::REG_MIX:   wet_level = v[16:0];
            default: ;   // unmapped index, no effect
        endcase
    endtask

    task automatic queue_pair(longint l, longint r);
        ffbe_pkg::in_item_t it;
        it.left_sample  = l[23:0];
        it.right_sample = r[23:0];
        pending_pairs.push_back(it);
    endtask

    // Wait until every pair is sent and every result is in, then let the block settle.
    task automatic drain;
        @(posedge clk);
        while (pending_pairs.size() > 0 || in_valid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // A stable-ish bandpass section: |a2| < 0.9, |a1| < 1 + a2.
    function automatic logic [53:0] stable_band();
        int g;
        int a1;
        int a2;
        int lim;
        g   = int'($urandom_range(0, 131071)) - 65536;
        a2  = int'($urandom_range(0, 117964)) - 58982;
        lim = 65536 + a2 - 1000;
        a1  = int'($urandom_range(0, 2 * lim)) - lim;
        return {a2[17:0], a1[17:0], g[17:0]};
    endfunction

    function automatic longint random_sample(int style);
        case (style)
            0:       return $signed(24'($urandom));
            1:       return longint'($urandom_range(0, 8191)) - 4096;
            default: return $urandom_range(1) ? 8388607 : -8388608;
        endcase
    endfunction

    initial
    begin
        int style;
        int mix_pick;
        for (int f = 0; f < 3; f++)
            band_coeffs[f] = '0;
        env_coeffs = '0;
        drive_q16 = '0;
        wet_level = '0;
        dry_hist = '{default: 0};
        band_hist = '{default: 0};
        env_track = '{default: 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset config: fully dry, output must equal input.
        queue_pair(8388607, -8388608);
        queue_pair(-8388608, 8388607);
        queue_pair(0, 0);
        queue_pair(-1, 1);
        queue_pair(1, -1);
        drain();

        // Full wet, maximum drive and envelope speed; peaks drive saturation.
        reg_write(ffbe_pkg::REG_F1, {10'd0, stable_band()});
        reg_write(ffbe_pkg::REG_F2, {10'd0, stable_band()});
        reg_write(ffbe_pkg::REG_F3, {10'd0, stable_band()});
        reg_write(ffbe_pkg::REG_ENV, 64'hF_FFFF_FFFF);
        reg_write(ffbe_pkg::REG_DRIVE, 64'd524287);
        reg_write(ffbe_pkg::REG_MIX, 64'(ffbe_pkg::MIX_ONE));
        repeat (3) queue_pair(8388607, 8388607);
        repeat (3) queue_pair(-8388608, -8388608);
        queue_pair(8388607, -8388608);
        queue_pair(-8388608, 8388607);
        queue_pair(0, 0);
        queue_pair(0, 0);
        drain();

        // Unstable coefficients push band outputs into 32-bit saturation;
        // mix above full behaves as full; unmapped indexes are ignored.
        reg_write(ffbe_pkg::REG_F1, 64'h001F_FFFF_FFFF_FFFF);
        reg_write(ffbe_pkg::REG_F2, {10'd0, 18'h1FFFF, 18'h20000, 18'h1FFFF});
        reg_write(ffbe_pkg::REG_F3, {10'd0, 18'h0FFFF, 18'h20000, 18'h1FFFF});
        reg_write(ffbe_pkg::REG_ENV, 64'd0);
        reg_write(ffbe_pkg::REG_DRIVE, 64'd0);
        reg_write(ffbe_pkg::REG_MIX, 64'd131071);
        reg_write(6, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(7, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
            queue_pair(i[0] ? 8388607 : -8388608, i[0] ? -8388608 : 8388607);
        drain();

        // Random phases with a fresh setting each time.
        for (int p = 0; p < 8; p++)
        begin
            reg_write(ffbe_pkg::REG_F1, {10'd0, stable_band()});
            reg_write(ffbe_pkg::REG_F2, {10'd0, stable_band()});
            reg_write(ffbe_pkg::REG_F3, {10'd0, stable_band()});
            reg_write(ffbe_pkg::REG_ENV, {28'd0, 36'({$urandom, $urandom})});
            reg_write(ffbe_pkg::REG_DRIVE, (p == 3) ? 64'd0 :
                                 (p == 5) ? 64'd524287 : 64'($urandom_range(0, 524287)));
            mix_pick = p % 4;
            case (mix_pick)
                0:       reg_write(ffbe_pkg::REG_MIX, 64'd0);
                1:       reg_write(ffbe_pkg::REG_MIX, 64'(ffbe_pkg::MIX_ONE));
                2:       reg_write(ffbe_pkg::REG_MIX, 64'($urandom_range(65537, 131071)));
                default: reg_write(ffbe_pkg::REG_MIX, 64'($urandom_range(0, 65536)));
            endcase
            no_idle = (p == 2);
            for (int i = 0; i < 185; i++)
            begin
                style = ($urandom_range(99) < 70) ? 0 : ($urandom_range(1) ? 1 : 2);
                queue_pair(random_sample(style), random_sample(style));
            end
            if (p == 4)
                hold_req++;
            drain();
            no_idle = 1'b0;
        end

        if (errors == 0 && expected_pairs.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
design/ffbe_pkg.sv
design/ffbe_ram.sv
design/formant_filter_bank_envelope.sv
tb/formant_filter_bank_envelope_test.sv
